### hw/rtl/decimal_vector_digit_strokes_assert.svh
// Assertion macros shared by the digit stroke generator RTL
`ifndef DECIMAL_VECTOR_DIGIT_STROKES_ASSERT_SVH
`define DECIMAL_VECTOR_DIGIT_STROKES_ASSERT_SVH

// same-cycle implication, idle during reset
`define DVDS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dvds check failed");

// next-cycle implication, idle during reset
`define DVDS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dvds check failed");

`endif

### hw/rtl/dvds_pkg.sv
// Shared types, constants and glyph ROM for the digit stroke generator
package dvds_pkg;

   // parameter defaults
   localparam int NUM_DIGITS_DEF = 4;
   localparam int GLYPH_UNIT_DEF = 32;
   localparam int VALUE_BITS_DEF = 16;

   // remainder width: holds up to 9999
   localparam int REM_BITS = 14;

   // register indexes
   localparam logic [2:0] CSR_ROW_Y          = 3'd0;
   localparam logic [2:0] CSR_START_X        = 3'd1;
   localparam logic [2:0] CSR_DIGIT_PITCH    = 3'd2;
   localparam logic [2:0] CSR_POSITION_SCALE = 3'd3;
   localparam logic [2:0] CSR_STROKE_SCALE   = 3'd4;
   localparam logic [2:0] CSR_INTENSITY      = 3'd5;

   // register reset values
   localparam logic signed [7:0] ROW_Y_RST          = 8'sd110;
   localparam logic signed [7:0] START_X_RST        = -8'sd110;
   localparam logic [6:0]        DIGIT_PITCH_RST    = 7'd10;
   localparam logic [7:0]        POSITION_SCALE_RST = 8'h7f;
   localparam logic [7:0]        STROKE_SCALE_RST   = 8'h18;
   localparam logic [6:0]        INTENSITY_RST      = 7'd95;

   localparam logic [1:0] DIGIT_POS_UNITS = 2'd3;

   // result kinds
   typedef enum logic [1:0] {
      KIND_POS  = 2'd0,
      KIND_MOVE = 2'd1,
      KIND_DRAW = 2'd2
   } kind_type;

   typedef struct packed {
      logic signed [7:0] row_y;
      logic signed [7:0] start_x;
      logic [6:0]        digit_pitch;
      logic [7:0]        position_scale;
      logic [7:0]        stroke_scale;
      logic [6:0]        intensity;
   } cfg_type;

   // handoff from digit splitter to stroke generator
   typedef struct packed {
      logic            valid;
      logic            ovf;
      logic [3:0][3:0] digits;
   } split_out_type;

   typedef struct packed {
      kind_type          kind;
      logic signed [2:0] dy;
      logic signed [2:0] dx;
   } stroke_type;

   function automatic int pow10(input int n);
      int p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   // subtrahend for each decade of the repeated subtraction
   function automatic logic [REM_BITS-1:0] decade(input logic [1:0] idx);
      logic [REM_BITS-1:0] r;
      case (idx)
         2'd0:    r = REM_BITS'(1000);
         2'd1:    r = REM_BITS'(100);
         default: r = REM_BITS'(10);
      endcase
      return r;
   endfunction

   // glyph units to 8-bit displacement, wrapping
   function automatic logic [7:0] unit_bits(input logic signed [2:0] units,
                                            input int unit_size);
      int prod;
      prod = int'(units) * unit_size;
      return prod[7:0];
   endfunction

   function automatic logic [2:0] glyph_len(input logic [3:0] d);
      logic [2:0] n;
      case (d)
         4'd0:    n = 3'd4;
         4'd1:    n = 3'd1;
         4'd2:    n = 3'd5;
         4'd3:    n = 3'd6;
         4'd4:    n = 3'd4;
         4'd5:    n = 3'd6;
         4'd6:    n = 3'd6;
         4'd7:    n = 3'd2;
         4'd8:    n = 3'd6;
         4'd9:    n = 3'd6;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic stroke_type mk(input kind_type k, input logic signed [2:0] y,
                                     input logic signed [2:0] x);
      stroke_type s;
      s.kind = k;
      s.dy   = y;
      s.dx   = x;
      return s;
   endfunction

   // ten-glyph stroke ROM, indexed by digit and stroke number
   function automatic stroke_type glyph_stroke(input logic [3:0] d, input logic [2:0] k);
      stroke_type s;
      case ({d, k})
         {4'd0, 3'd0}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd0, 3'd1}: s = mk(KIND_DRAW,  3'sd2,  3'sd0);
         {4'd0, 3'd2}: s = mk(KIND_DRAW,  3'sd0,  3'sd1);
         {4'd0, 3'd3}: s = mk(KIND_DRAW, -3'sd2,  3'sd0);
         {4'd1, 3'd0}: s = mk(KIND_DRAW,  3'sd2,  3'sd0);
         {4'd2, 3'd0}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd2, 3'd1}: s = mk(KIND_DRAW,  3'sd1,  3'sd0);
         {4'd2, 3'd2}: s = mk(KIND_DRAW,  3'sd0,  3'sd1);
         {4'd2, 3'd3}: s = mk(KIND_DRAW,  3'sd1,  3'sd0);
         {4'd2, 3'd4}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd3, 3'd0}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd3, 3'd1}: s = mk(KIND_MOVE,  3'sd0,  3'sd1);
         {4'd3, 3'd2}: s = mk(KIND_DRAW,  3'sd2,  3'sd0);
         {4'd3, 3'd3}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd3, 3'd4}: s = mk(KIND_MOVE, -3'sd1,  3'sd0);
         {4'd3, 3'd5}: s = mk(KIND_DRAW,  3'sd0,  3'sd1);
         {4'd4, 3'd0}: s = mk(KIND_DRAW,  3'sd2,  3'sd0);
         {4'd4, 3'd1}: s = mk(KIND_MOVE, -3'sd1,  3'sd0);
         {4'd4, 3'd2}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd4, 3'd3}: s = mk(KIND_DRAW,  3'sd1,  3'sd0);
         {4'd5, 3'd0}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd5, 3'd1}: s = mk(KIND_MOVE,  3'sd0,  3'sd1);
         {4'd5, 3'd2}: s = mk(KIND_DRAW,  3'sd1,  3'sd0);
         {4'd5, 3'd3}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd5, 3'd4}: s = mk(KIND_DRAW,  3'sd1,  3'sd0);
         {4'd5, 3'd5}: s = mk(KIND_DRAW,  3'sd0,  3'sd1);
         {4'd6, 3'd0}: s = mk(KIND_DRAW,  3'sd1,  3'sd0);
         {4'd6, 3'd1}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd6, 3'd2}: s = mk(KIND_MOVE, -3'sd1,  3'sd1);
         {4'd6, 3'd3}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd6, 3'd4}: s = mk(KIND_DRAW,  3'sd2,  3'sd0);
         {4'd6, 3'd5}: s = mk(KIND_DRAW,  3'sd0,  3'sd1);
         {4'd7, 3'd0}: s = mk(KIND_DRAW,  3'sd2,  3'sd0);
         {4'd7, 3'd1}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd8, 3'd0}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd8, 3'd1}: s = mk(KIND_DRAW,  3'sd2,  3'sd0);
         {4'd8, 3'd2}: s = mk(KIND_DRAW,  3'sd0,  3'sd1);
         {4'd8, 3'd3}: s = mk(KIND_DRAW, -3'sd2,  3'sd0);
         {4'd8, 3'd4}: s = mk(KIND_MOVE,  3'sd1,  3'sd0);
         {4'd8, 3'd5}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd9, 3'd0}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd9, 3'd1}: s = mk(KIND_MOVE,  3'sd0,  3'sd1);
         {4'd9, 3'd2}: s = mk(KIND_DRAW,  3'sd2,  3'sd0);
         {4'd9, 3'd3}: s = mk(KIND_DRAW,  3'sd0, -3'sd1);
         {4'd9, 3'd4}: s = mk(KIND_DRAW, -3'sd1,  3'sd0);
         {4'd9, 3'd5}: s = mk(KIND_DRAW,  3'sd0,  3'sd1);
         default:      s = mk(KIND_POS,   3'sd0,  3'sd0);
      endcase
      return s;
   endfunction

endpackage

### hw/rtl/dvds_digit_split.sv
// Clamp and decimal split of the input word by repeated subtraction
module dvds_digit_split
   import dvds_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output split_out_type         split_out,
   input  logic                  split_take
);

   localparam int LIMIT = pow10(NUM_DIGITS) - 1;

   typedef enum logic [2:0] {
      SPLIT_IDLE = 3'b001,
      SPLIT_SUB  = 3'b010,
      SPLIT_HOLD = 3'b100
   } split_state_type;

   split_state_type     state_ff, state_in;
   logic [REM_BITS-1:0] rem_ff;
   logic [1:0]          idx_ff;
   logic                ovf_ff;
   logic [3:0]          digit_ff [4];
   logic [REM_BITS:0]   diff;
   logic                accept;
   logic                too_big;

   assign accept  = req_valid && (state_ff == SPLIT_IDLE);
   assign too_big = req_value > VALUE_BITS'(LIMIT);

   // shared subtractor; top bit is the borrow
   assign diff = {1'b0, rem_ff} - {1'b0, decade(idx_ff)};

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SPLIT_IDLE: if (req_valid) state_in = SPLIT_SUB;
         SPLIT_SUB:  if (diff[REM_BITS] && idx_ff == 2'd2) state_in = SPLIT_HOLD;
         SPLIT_HOLD: if (split_take) state_in = SPLIT_IDLE;
         default:    state_in = SPLIT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SPLIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // remainder, decade index and digit counters
   always_ff @(posedge clock) begin
      if (accept) begin
         rem_ff      <= too_big ? REM_BITS'(LIMIT) : req_value[REM_BITS-1:0];
         ovf_ff      <= too_big;
         idx_ff      <= 2'd0;
         digit_ff[0] <= 4'd0;
         digit_ff[1] <= 4'd0;
         digit_ff[2] <= 4'd0;
         digit_ff[3] <= 4'd0;
      end else if (state_ff == SPLIT_SUB) begin
         if (!diff[REM_BITS]) begin
            rem_ff           <= diff[REM_BITS-1:0];
            digit_ff[idx_ff] <= digit_ff[idx_ff] + 4'd1;
         end else if (idx_ff == 2'd2) begin
            digit_ff[3] <= rem_ff[3:0];
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   assign req_stall        = (state_ff != SPLIT_IDLE);
   assign split_out.valid  = (state_ff == SPLIT_HOLD);
   assign split_out.ovf    = ovf_ff;
   assign split_out.digits = {digit_ff[3], digit_ff[2], digit_ff[1], digit_ff[0]};

endmodule

### hw/rtl/dvds_stroke_gen.sv
// Stroke sequencer: position item and glyph strokes per digit, output register
module dvds_stroke_gen
   import dvds_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF,
   parameter int GLYPH_UNIT = GLYPH_UNIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  split_out_type     split_out,
   output logic              split_take,
   input  cfg_type           cfg,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic signed [7:0] rsp_dy,
   output logic signed [7:0] rsp_dx,
   output logic [7:0]        rsp_scale,
   output logic [6:0]        rsp_beam_level,
   output logic [1:0]        rsp_digit_pos,
   output logic [3:0]        rsp_digit_value,
   output logic              rsp_overflow,
   output logic              rsp_last
);

   localparam logic [1:0] FIRST_POS = 2'(4 - NUM_DIGITS);

   typedef enum logic [1:0] {
      EMIT_IDLE = 2'b01,
      EMIT_RUN  = 2'b10
   } emit_state_type;

   emit_state_type  state_ff, state_in;
   logic [1:0]      pos_ff;
   logic [2:0]      step_ff;
   logic [7:0]      col_ff;
   logic            ovf_ff;
   logic [3:0][3:0] digits_ff;
   logic            rsp_valid_ff;
   logic            out_free;
   logic            fire;
   logic [3:0]      d;
   logic            digit_end;
   logic            num_end;
   stroke_type      stroke;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = (state_ff == EMIT_RUN) && out_free;
   assign split_take = (state_ff == EMIT_IDLE) && split_out.valid;

   assign d         = digits_ff[pos_ff];
   assign digit_end = (step_ff == glyph_len(d));
   assign num_end   = digit_end && (pos_ff == DIGIT_POS_UNITS);
   assign stroke    = glyph_stroke(d, 3'(step_ff - 3'd1));

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EMIT_IDLE: if (split_out.valid) state_in = EMIT_RUN;
         EMIT_RUN:  if (fire && num_end) state_in = EMIT_IDLE;
         default:   state_in = EMIT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EMIT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_free) rsp_valid_ff <= fire;
      end
   end

   // digit position, stroke step and column
   always_ff @(posedge clock) begin
      if (split_take) begin
         digits_ff <= split_out.digits;
         ovf_ff    <= split_out.ovf;
         pos_ff    <= FIRST_POS;
         step_ff   <= 3'd0;
         col_ff    <= cfg.start_x;
      end else if (fire) begin
         if (digit_end) begin
            pos_ff  <= pos_ff + 2'd1;
            step_ff <= 3'd0;
            col_ff  <= col_ff + {1'b0, cfg.digit_pitch};
         end else begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_digit_pos   <= pos_ff;
         rsp_digit_value <= d;
         rsp_overflow    <= ovf_ff;
         rsp_last        <= num_end;
         if (step_ff == 3'd0) begin
            rsp_kind       <= KIND_POS;
            rsp_dy         <= cfg.row_y;
            rsp_dx         <= col_ff;
            rsp_scale      <= cfg.position_scale;
            rsp_beam_level <= 7'd0;
         end else begin
            rsp_kind       <= stroke.kind;
            rsp_dy         <= unit_bits(stroke.dy, GLYPH_UNIT);
            rsp_dx         <= unit_bits(stroke.dx, GLYPH_UNIT);
            rsp_scale      <= cfg.stroke_scale;
            rsp_beam_level <= cfg.intensity;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/decimal_vector_digit_strokes.sv
// Top level of the decimal digit vector stroke generator
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_value
//   rsp      out        rsp_valid/rsp_stall  kind, dy, dx, scale, beam_level,
//                                            digit_pos, digit_value, overflow, last
//   csr      in         csr_we               csr_index, csr_wdata
//
// The splitter works through the thousands, hundreds and tens digits, one subtract
// per cycle, then hands the digits to the stroke sequencer and accepts the next
// word in the cycle after the handoff, so both work on different words at once.
// The sequencer emits one result word per cycle unless rsp_stall holds it:
// NUM_DIGITS position items plus glyph strokes, up to 28 words per number.
// Reset is synchronous; it clears control state and loads register defaults.
// rsp_stall holds a valid output word and pauses the sequencer in place.
module decimal_vector_digit_strokes
   import dvds_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF,
   parameter int GLYPH_UNIT = GLYPH_UNIT_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic signed [7:0]     rsp_dy,
   output logic signed [7:0]     rsp_dx,
   output logic [7:0]            rsp_scale,
   output logic [6:0]            rsp_beam_level,
   output logic [1:0]            rsp_digit_pos,
   output logic [3:0]            rsp_digit_value,
   output logic                  rsp_overflow,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_wdata
);

   cfg_type       cfg_ff;
   split_out_type split_out;
   logic          split_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_y          <= ROW_Y_RST;
         cfg_ff.start_x        <= START_X_RST;
         cfg_ff.digit_pitch    <= DIGIT_PITCH_RST;
         cfg_ff.position_scale <= POSITION_SCALE_RST;
         cfg_ff.stroke_scale   <= STROKE_SCALE_RST;
         cfg_ff.intensity      <= INTENSITY_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_Y:          cfg_ff.row_y          <= csr_wdata;
            CSR_START_X:        cfg_ff.start_x        <= csr_wdata;
            CSR_DIGIT_PITCH:    cfg_ff.digit_pitch    <= csr_wdata[6:0];
            CSR_POSITION_SCALE: cfg_ff.position_scale <= csr_wdata;
            CSR_STROKE_SCALE:   cfg_ff.stroke_scale   <= csr_wdata;
            CSR_INTENSITY:      cfg_ff.intensity      <= csr_wdata[6:0];
            default:            ;
         endcase
      end
   end

   dvds_digit_split #(
      .NUM_DIGITS (NUM_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_split (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .split_out  (split_out),
      .split_take (split_take)
   );

   dvds_stroke_gen #(
      .NUM_DIGITS (NUM_DIGITS),
      .GLYPH_UNIT (GLYPH_UNIT)
   ) u_strokes (
      .clock           (clock),
      .reset           (reset),
      .split_out       (split_out),
      .split_take      (split_take),
      .cfg             (cfg_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_dy          (rsp_dy),
      .rsp_dx          (rsp_dx),
      .rsp_scale       (rsp_scale),
      .rsp_beam_level  (rsp_beam_level),
      .rsp_digit_pos   (rsp_digit_pos),
      .rsp_digit_value (rsp_digit_value),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

   `include "decimal_vector_digit_strokes_assert.svh"

   // position items are blanked
   `DVDS_ASSERT_IMP(a_pos_blank, clock, reset, rsp_valid && rsp_kind == KIND_POS, rsp_beam_level == 7'd0)
   // a clamped number shows only nines
   `DVDS_ASSERT_IMP(a_ovf_nines, clock, reset, rsp_valid && rsp_overflow, rsp_digit_value == 4'd9)
   // the final word belongs to the units digit
   `DVDS_ASSERT_IMP(a_last_units, clock, reset, rsp_valid && rsp_last, rsp_digit_pos == DIGIT_POS_UNITS)
   // after a handoff the split output is no longer valid
   `DVDS_ASSERT_NXT(a_take_frees, clock, reset, split_take, !split_out.valid)

endmodule

### tb/tb.sv
// Self-checking testbench for the decimal digit vector stroke generator
module tb
   import dvds_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 500;
   localparam int RANDOM_WORDS = 52;

   // indexes past the register file, writes there must be ignored
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   // one stroke word as it leaves the block
   typedef struct packed {
      kind_type          kind;
      logic signed [7:0] dy;
      logic signed [7:0] dx;
      logic [7:0]        scale;
      logic [6:0]        beam_level;
      logic [1:0]        digit_pos;
      logic [3:0]        digit_value;
      logic              overflow;
      logic              last;
   } stroke_word_type;

   // one glyph stroke in glyph units
   typedef struct packed {
      kind_type          kind;
      logic signed [2:0] uy;
      logic signed [2:0] ux;
   } font_seg_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [VALUE_BITS_DEF-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_kind;
   logic signed [7:0]       rsp_dy;
   logic signed [7:0]       rsp_dx;
   logic [7:0]              rsp_scale;
   logic [6:0]              rsp_beam_level;
   logic [1:0]              rsp_digit_pos;
   logic [3:0]              rsp_digit_value;
   logic                    rsp_overflow;
   logic                    rsp_last;
   logic                    csr_we = 1'b0;
   logic [2:0]              csr_index = '0;
   logic [7:0]              csr_wdata = '0;

   cfg_type                 display_cfg;
   logic [15:0]             pending_values[$];
   stroke_word_type         expected_words[$];
   int                      idle_pct = 0;
   int                      stall_pct = 0;
   logic                    hold_on = 1'b0;
   int                      errors = 0;
   int                      cycles = 0;

   decimal_vector_digit_strokes dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_dy         (rsp_dy),
      .rsp_dx         (rsp_dx),
      .rsp_scale      (rsp_scale),
      .rsp_beam_level (rsp_beam_level),
      .rsp_digit_pos  (rsp_digit_pos),
      .rsp_digit_value(rsp_digit_value),
      .rsp_overflow   (rsp_overflow),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic font_seg_type seg(input kind_type k, input int y, input int x);
      font_seg_type r;
      r.kind = k;
      r.uy   = y[2:0];
      r.ux   = x[2:0];
      return r;
   endfunction

   // stroke font; KIND_POS marks the end of a glyph
   function automatic font_seg_type font_seg(input logic [3:0] d, input logic [2:0] k);
      font_seg_type r;
      case ({d, k})
         {4'd0, 3'd0}: r = seg(KIND_DRAW,  0, -1);
         {4'd0, 3'd1}: r = seg(KIND_DRAW,  2,  0);
         {4'd0, 3'd2}: r = seg(KIND_DRAW,  0,  1);
         {4'd0, 3'd3}: r = seg(KIND_DRAW, -2,  0);
         {4'd1, 3'd0}: r = seg(KIND_DRAW,  2,  0);
         {4'd2, 3'd0}: r = seg(KIND_DRAW,  0, -1);
         {4'd2, 3'd1}: r = seg(KIND_DRAW,  1,  0);
         {4'd2, 3'd2}: r = seg(KIND_DRAW,  0,  1);
         {4'd2, 3'd3}: r = seg(KIND_DRAW,  1,  0);
         {4'd2, 3'd4}: r = seg(KIND_DRAW,  0, -1);
         {4'd3, 3'd0}: r = seg(KIND_DRAW,  0, -1);
         {4'd3, 3'd1}: r = seg(KIND_MOVE,  0,  1);
         {4'd3, 3'd2}: r = seg(KIND_DRAW,  2,  0);
         {4'd3, 3'd3}: r = seg(KIND_DRAW,  0, -1);
         {4'd3, 3'd4}: r = seg(KIND_MOVE, -1,  0);
         {4'd3, 3'd5}: r = seg(KIND_DRAW,  0,  1);
         {4'd4, 3'd0}: r = seg(KIND_DRAW,  2,  0);
         {4'd4, 3'd1}: r = seg(KIND_MOVE, -1,  0);
         {4'd4, 3'd2}: r = seg(KIND_DRAW,  0, -1);
         {4'd4, 3'd3}: r = seg(KIND_DRAW,  1,  0);
         {4'd5, 3'd0}: r = seg(KIND_DRAW,  0, -1);
         {4'd5, 3'd1}: r = seg(KIND_MOVE,  0,  1);
         {4'd5, 3'd2}: r = seg(KIND_DRAW,  1,  0);
         {4'd5, 3'd3}: r = seg(KIND_DRAW,  0, -1);
         {4'd5, 3'd4}: r = seg(KIND_DRAW,  1,  0);
         {4'd5, 3'd5}: r = seg(KIND_DRAW,  0,  1);
         {4'd6, 3'd0}: r = seg(KIND_DRAW,  1,  0);
         {4'd6, 3'd1}: r = seg(KIND_DRAW,  0, -1);
         {4'd6, 3'd2}: r = seg(KIND_MOVE, -1,  1);
         {4'd6, 3'd3}: r = seg(KIND_DRAW,  0, -1);
         {4'd6, 3'd4}: r = seg(KIND_DRAW,  2,  0);
         {4'd6, 3'd5}: r = seg(KIND_DRAW,  0,  1);
         {4'd7, 3'd0}: r = seg(KIND_DRAW,  2,  0);
         {4'd7, 3'd1}: r = seg(KIND_DRAW,  0, -1);
         {4'd8, 3'd0}: r = seg(KIND_DRAW,  0, -1);
         {4'd8, 3'd1}: r = seg(KIND_DRAW,  2,  0);
         {4'd8, 3'd2}: r = seg(KIND_DRAW,  0,  1);
         {4'd8, 3'd3}: r = seg(KIND_DRAW, -2,  0);
         {4'd8, 3'd4}: r = seg(KIND_MOVE,  1,  0);
         {4'd8, 3'd5}: r = seg(KIND_DRAW,  0, -1);
         {4'd9, 3'd0}: r = seg(KIND_DRAW,  0, -1);
         {4'd9, 3'd1}: r = seg(KIND_MOVE,  0,  1);
         {4'd9, 3'd2}: r = seg(KIND_DRAW,  2,  0);
         {4'd9, 3'd3}: r = seg(KIND_DRAW,  0, -1);
         {4'd9, 3'd4}: r = seg(KIND_DRAW, -1,  0);
         {4'd9, 3'd5}: r = seg(KIND_DRAW,  0,  1);
         default:      r = seg(KIND_POS,   0,  0);
      endcase
      return r;
   endfunction

   // queue the stroke words of one number; a word is held back one step so
   // that the final one can be tagged as last
   task automatic predict_number(input logic [15:0] value);
      stroke_word_type w, held;
      font_seg_type    s;
      logic [7:0]      col;
      logic [3:0]      dig;
      logic            ovf;
      bit              have_held;
      int              n, div, prod;
      n = value;
      ovf = (n > 9999);
      if (ovf) n = 9999;
      col = display_cfg.start_x;
      div = 1000;
      have_held = 0;
      for (int pos = 0; pos < 4; pos++) begin
         dig = 4'((n / div) % 10);
         div = div / 10;
         w.kind        = KIND_POS;
         w.dy          = display_cfg.row_y;
         w.dx          = col;
         w.scale       = display_cfg.position_scale;
         w.beam_level  = '0;
         w.digit_pos   = 2'(pos);
         w.digit_value = dig;
         w.overflow    = ovf;
         w.last        = 1'b0;
         if (have_held) expected_words.push_back(held);
         held = w;
         have_held = 1;
         for (int k = 0; k < 6; k++) begin
            s = font_seg(dig, 3'(k));
            if (s.kind == KIND_POS) break;
            w.kind       = s.kind;
            prod         = s.uy * GLYPH_UNIT_DEF;
            w.dy         = prod[7:0];
            prod         = s.ux * GLYPH_UNIT_DEF;
            w.dx         = prod[7:0];
            w.scale      = display_cfg.stroke_scale;
            w.beam_level = display_cfg.intensity;
            expected_words.push_back(held);
            held = w;
         end
         col = col + {1'b0, display_cfg.digit_pitch};
      end
      held.last = 1'b1;
      expected_words.push_back(held);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // driver: offers pending numbers, predicts on every accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_number(req_value);
         if (!req_valid || !req_stall) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_value <= pending_values.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each accepted stroke word with the oldest prediction
   always @(posedge clock) begin : monitor
      stroke_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("stroke word with none expected");
               errors++;
            end else begin
               want = expected_words.pop_front();
               check_field("kind", int'(want.kind), int'(rsp_kind));
               check_field("dy", int'(want.dy), int'(rsp_dy));
               check_field("dx", int'(want.dx), int'(rsp_dx));
               check_field("scale", int'(want.scale), int'(rsp_scale));
               check_field("beam_level", int'(want.beam_level), int'(rsp_beam_level));
               check_field("digit_pos", int'(want.digit_pos), int'(rsp_digit_pos));
               check_field("digit_value", int'(want.digit_value), int'(rsp_digit_value));
               check_field("overflow", int'(want.overflow), int'(rsp_overflow));
               check_field("last", int'(want.last), int'(rsp_last));
            end
         end
         rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // one register write, mirrored into the predictor's copy; the enable
   // drops for a cycle before the next write
   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_ROW_Y:          display_cfg.row_y          = data;
         CSR_START_X:        display_cfg.start_x        = data;
         CSR_DIGIT_PITCH:    display_cfg.digit_pitch    = data[6:0];
         CSR_POSITION_SCALE: display_cfg.position_scale = data;
         CSR_STROKE_SCALE:   display_cfg.stroke_scale   = data;
         CSR_INTENSITY:      display_cfg.intensity      = data[6:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] row, input logic [7:0] start,
                                input logic [7:0] pitch, input logic [7:0] pscale,
                                input logic [7:0] sscale, input logic [7:0] level);
      write_reg(CSR_ROW_Y, row);
      write_reg(CSR_START_X, start);
      write_reg(CSR_DIGIT_PITCH, pitch);
      write_reg(CSR_POSITION_SCALE, pscale);
      write_reg(CSR_STROKE_SCALE, sscale);
      write_reg(CSR_INTENSITY, level);
   endtask

   task automatic load_random_settings();
      load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // mostly displayable numbers, the rest anywhere in the 16-bit range
   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 80) pending_values.push_back(16'($urandom_range(9999)));
         else pending_values.push_back(16'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (pending_values.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_pace(input int idle, input int stall);
      idle_pct  <= idle;
      stall_pct <= stall;
   endtask

   initial begin
      display_cfg.row_y          = ROW_Y_RST;
      display_cfg.start_x        = START_X_RST;
      display_cfg.digit_pitch    = DIGIT_PITCH_RST;
      display_cfg.position_scale = POSITION_SCALE_RST;
      display_cfg.stroke_scale   = STROKE_SCALE_RST;
      display_cfg.intensity      = INTENSITY_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, no idling: field extremes, every digit, clamping
      set_pace(0, 0);
      pending_values.push_back(16'd0);
      pending_values.push_back(16'd1);
      pending_values.push_back(16'd9999);
      pending_values.push_back(16'd10000);
      pending_values.push_back(16'd65535);
      pending_values.push_back(16'd1234);
      pending_values.push_back(16'd5678);
      pending_values.push_back(16'd9090);
      pending_values.push_back(16'd7);
      pending_values.push_back(16'd1000);
      pending_values.push_back(16'd100);
      pending_values.push_back(16'd10);
      pending_values.push_back(16'd4567);
      pending_values.push_back(16'd8901);
      pending_values.push_back(16'd2345);
      pending_values.push_back(16'd6789);
      pending_values.push_back(16'd3333);
      pending_values.push_back(16'd32768);
      pending_values.push_back(16'd16384);
      queue_random(RANDOM_WORDS);
      wait_drained();

      // all registers at their top, column wraps; sender mostly idle
      load_settings(8'h7f, 8'h7f, 8'h7f, 8'hff, 8'hff, 8'h7f);
      set_pace(79, 0);
      pending_values.push_back(16'd9999);
      queue_random(RANDOM_WORDS);
      wait_drained();

      // all registers at their bottom; receiver mostly stalling
      load_settings(8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
      set_pace(0, 79);
      pending_values.push_back(16'd8888);
      queue_random(RANDOM_WORDS);
      wait_drained();

      // random settings, both sides idling, and a long receiver hold-off
      load_random_settings();
      set_pace(35, 35);
      queue_random(RANDOM_WORDS);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
      wait_drained();

      // writes past the register file change nothing
      load_random_settings();
      write_reg(CSR_SPARE_LO, 8'($urandom));
      write_reg(CSR_SPARE_HI, 8'($urandom));
      set_pace(0, 0);
      queue_random(RANDOM_WORDS);
      wait_drained();

      load_random_settings();
      set_pace(35, 35);
      queue_random(RANDOM_WORDS);
      wait_drained();

      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/dvds_pkg.sv
hw/rtl/dvds_digit_split.sv
hw/rtl/dvds_stroke_gen.sv
hw/rtl/decimal_vector_digit_strokes.sv
tb/tb.sv
